/* hdl/torque_to_pwm_duty_mapper_top_macros.svh */
// ============================================================================
// Torque to PWM duty mapper - assertion macros
// Shared concurrent assertion forms. Each use expects clk and rst_n in scope.
// ============================================================================
`ifndef TORQUE_TO_PWM_DUTY_MAPPER_TOP_MACROS_SVH
`define TORQUE_TO_PWM_DUTY_MAPPER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTPDM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTPDM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ttpdm_pkg.sv */
// ============================================================================
// Torque to PWM duty mapper - package
// Widths, codes, constants and the structures passed between pipeline parts.
// ============================================================================
package ttpdm_pkg;

    localparam int DUTY_BITS   = 16;
    localparam int TORQUE_BITS = 17;
    localparam int MAG_BITS    = 16;
    localparam int BAL_BITS    = 8;
    localparam int SPAN_BITS   = MAG_BITS + 1;
    localparam int LO_BITS     = MAG_BITS + 2;
    localparam int PROD_BITS   = MAG_BITS + SPAN_BITS;
    localparam int DIV_STEPS   = SPAN_BITS;

    // Register indexes of the configuration channel.
    localparam logic [2:0] REG_DRIVE_MODE = 3'd0;
    localparam logic [2:0] REG_MAX_TORQUE = 3'd1;
    localparam logic [2:0] REG_MIN_TORQUE = 3'd2;
    localparam logic [2:0] REG_BALANCE    = 3'd3;
    localparam logic [2:0] REG_PWM_TOP    = 3'd4;

    typedef enum logic [1:0] {
        MODE_PM      = 2'd0,
        MODE_ZFH     = 2'd1,
        MODE_PWM_DIR = 2'd2
    } drive_mode_t;

    typedef struct packed {
        drive_mode_t          mode;
        logic [MAG_BITS-1:0]  max_torque;
        logic [MAG_BITS-1:0]  min_torque;
        logic [BAL_BITS-1:0]  balance;
        logic [DUTY_BITS-1:0] pwm_top;
    } cfg_t;

    // Output routing for one item.
    typedef struct packed {
        logic sel_b;
        logic kill;
        logic dir_en;
    } ctl_t;

    // Fields that ride alongside the division unchanged.
    typedef struct packed {
        logic signed [LO_BITS-1:0] lo;
        logic                      span_neg;
        ctl_t                      ctl;
    } side_t;

    // Partial remainder, and dividend low bits with quotient bits shifted in.
    typedef struct packed {
        logic [MAG_BITS-1:0]  rem;
        logic [SPAN_BITS-1:0] pq;
        side_t                side;
    } div_t;

endpackage

/* hdl/torque_to_pwm_duty_mapper_top.sv */
// ============================================================================
// Torque to PWM duty mapper - top level
// Maps each signed torque command to two PWM compare values and a direction
// or enable bit. The block is fully pipelined: it takes one torque transfer
// per clock while its input is not stalled. Each result passes through the
// five front-end stages, the seventeen stages of the restoring divider (one
// quotient bit per stage, dividing by max_torque) and the output register.
// Results come out in order, one per input. Stalls on the result side hold
// the pipeline stage by stage, so empty stages still fill while a finished
// result waits, and the input is stalled only once every stage holds an
// item. Configuration registers are written through their own channel,
// which is always ready; they must only be changed while no transfer is in
// flight, because every stage reads them directly. Register indexes are 0
// drive_mode, 1 max_torque, 2 min_torque, 3 balance and 4 pwm_top; other
// indexes are ignored.
// ============================================================================
`include "torque_to_pwm_duty_mapper_top_macros.svh"

module torque_to_pwm_duty_mapper_top (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [2:0]                               cfg_index,
    input  logic [ttpdm_pkg::MAG_BITS-1:0]           cfg_data,
    input  logic                                     torque_valid,
    output logic                                     torque_stall,
    input  logic signed [ttpdm_pkg::TORQUE_BITS-1:0] torque,
    output logic                                     duty_valid,
    input  logic                                     duty_stall,
    output logic [ttpdm_pkg::DUTY_BITS-1:0]          duty_a,
    output logic [ttpdm_pkg::DUTY_BITS-1:0]          duty_b,
    output logic                                     dir_enable
);
    import ttpdm_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. The write channel never back-pressures.
    // ------------------------------------------------------------------
    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DRIVE_MODE: cfg_next.mode       = drive_mode_t'(cfg_data[1:0]);
                REG_MAX_TORQUE: cfg_next.max_torque = cfg_data;
                REG_MIN_TORQUE: cfg_next.min_torque = cfg_data;
                REG_BALANCE:    cfg_next.balance    = cfg_data[BAL_BITS-1:0];
                REG_PWM_TOP:    cfg_next.pwm_top    = cfg_data[DUTY_BITS-1:0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= MODE_PM;
            cfg_reg.max_torque <= 16'd16383;
            cfg_reg.min_torque <= 16'd0;
            cfg_reg.balance    <= 8'd128;
            cfg_reg.pwm_top    <= 16'd16383;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Front end: saturation, balance scaling and the span product.
    // ------------------------------------------------------------------
    logic front_ready;
    logic chain_valid [DIV_STEPS+1];
    logic chain_ready [DIV_STEPS+1];
    div_t chain_data  [DIV_STEPS+1];

    ttpdm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (torque_valid),
        .torque    (torque),
        .in_ready  (front_ready),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0]),
        .out_ready (chain_ready[0])
    );

    assign torque_stall = !front_ready;

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage, most significant first.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        ttpdm_div_stage u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .divisor   (cfg_reg.max_torque),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .in_ready  (chain_ready[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1]),
            .out_ready (chain_ready[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Back end: sign, offset, clamp and the output register.
    // ------------------------------------------------------------------
    ttpdm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (chain_valid[DIV_STEPS]),
        .in_data    (chain_data[DIV_STEPS]),
        .in_ready   (chain_ready[DIV_STEPS]),
        .out_valid  (duty_valid),
        .duty_a     (duty_a),
        .duty_b     (duty_b),
        .dir_enable (dir_enable),
        .out_stall  (duty_stall)
    );

    // Channel B only ever carries a value in the two-channel mode, and then
    // channel A is idle.
    `TTPDM_ASSERT_IMP(a_b_only_in_pm, duty_valid && (duty_b != '0), (cfg_reg.mode == MODE_PM) && (duty_a == '0), "channel B driven outside two-channel mode")

    // Both compare values respect the timer top.
    `TTPDM_ASSERT_IMP(a_duty_clamped, duty_valid, (duty_a <= cfg_reg.pwm_top) && (duty_b <= cfg_reg.pwm_top), "compare value above timer top")

    // A write to the timer top lands in the register in the next cycle.
    `TTPDM_ASSERT_NXT(a_top_write, cfg_valid && cfg_ready && (cfg_index == REG_PWM_TOP), cfg_reg.pwm_top == $past(cfg_data), "timer top write lost")

endmodule

/* hdl/ttpdm_front.sv */
// ============================================================================
// Torque to PWM duty mapper - front end
// Five stages: saturation and balance product, divide by 255 in two steps,
// span selection per mode, and the magnitude times span product.
// ============================================================================
module ttpdm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ttpdm_pkg::cfg_t                    cfg,
    input  logic                               in_valid,
    input  logic signed [ttpdm_pkg::TORQUE_BITS-1:0] torque,
    output logic                               in_ready,
    output logic                               out_valid,
    output ttpdm_pkg::div_t                    out_data,
    input  logic                               out_ready
);
    import ttpdm_pkg::*;

    localparam logic [BAL_BITS-1:0] BAL_NEUTRAL = 8'd128;
    localparam logic [BAL_BITS:0]   BAL_OFS_LO  = 9'd127;
    localparam logic [BAL_BITS:0]   BAL_OFS_HI  = 9'd383;
    localparam logic [23:0]         BAL_DIV     = 24'd255;
    localparam logic [23:0]         BAL_DIV2    = 24'(2 * 255);
    localparam logic [23:0]         BAL_DIV3    = 24'(3 * 255);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s2_ready, s3_ready, s4_ready, s5_ready;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = !s1_valid_reg || s2_ready;

    // ---------------- stage 1: magnitude, saturation, balance product
    logic [TORQUE_BITS-1:0] raw;
    logic [TORQUE_BITS-1:0] mag_full;
    logic                   in_neg;
    logic                   in_pos;
    logic [MAG_BITS-1:0]    mag_sat;
    logic [BAL_BITS-1:0]    bal_k;
    logic [23:0]            bal_prod;

    always_comb
    begin
        raw      = torque;
        in_neg   = raw[TORQUE_BITS-1];
        mag_full = in_neg ? (TORQUE_BITS'(0) - raw) : raw;
        in_pos   = !in_neg && (raw != '0);
        if (mag_full > {1'b0, cfg.max_torque})
        begin
            mag_sat = cfg.max_torque;
        end
        else
        begin
            mag_sat = mag_full[MAG_BITS-1:0];
        end
        if (cfg.balance < BAL_NEUTRAL)
        begin
            bal_k = BAL_BITS'({1'b0, cfg.balance} + BAL_OFS_LO);
        end
        else
        begin
            bal_k = BAL_BITS'(BAL_OFS_HI - {1'b0, cfg.balance});
        end
        bal_prod = {8'd0, cfg.max_torque} * {16'd0, bal_k};
    end

    logic [MAG_BITS-1:0] s1_mag_reg;
    logic                s1_neg_reg, s1_pos_reg;
    logic [23:0]         s1_bal_reg;

    // ---------------- stage 2: quotient estimate of the balance product by 255
    logic [24:0]         bal_sum;
    logic [MAG_BITS-1:0] bal_q0;

    always_comb
    begin
        bal_sum = {1'b0, s1_bal_reg} + 25'(s1_bal_reg >> 8) + 25'(s1_bal_reg >> 16);
        bal_q0  = bal_sum[23:8];
    end

    logic [MAG_BITS-1:0] s2_mag_reg;
    logic                s2_neg_reg, s2_pos_reg;
    logic [23:0]         s2_bal_reg;
    logic [MAG_BITS-1:0] s2_q0_reg;

    // ---------------- stage 3: remainder correction of the estimate
    logic [23:0]         bal_rem;
    logic [1:0]          bal_corr;
    logic [MAG_BITS-1:0] bal_hi;

    always_comb
    begin
        bal_rem = s2_bal_reg - 24'(s2_q0_reg) * BAL_DIV;
        if (bal_rem >= BAL_DIV3)
        begin
            bal_corr = 2'd3;
        end
        else if (bal_rem >= BAL_DIV2)
        begin
            bal_corr = 2'd2;
        end
        else if (bal_rem >= BAL_DIV)
        begin
            bal_corr = 2'd1;
        end
        else
        begin
            bal_corr = 2'd0;
        end
        bal_hi = s2_q0_reg + MAG_BITS'(bal_corr);
    end

    logic [MAG_BITS-1:0] s3_mag_reg;
    logic                s3_neg_reg, s3_pos_reg;
    logic [MAG_BITS-1:0] s3_hi_reg;

    // ---------------- stage 4: low end and span for the selected mode
    logic [MAG_BITS-1:0]     half;
    logic signed [LO_BITS:0] lo;
    logic signed [LO_BITS:0] hi;
    logic signed [LO_BITS:0] span;
    logic signed [LO_BITS:0] span_abs;
    logic signed [LO_BITS:0] n_ext;
    logic signed [LO_BITS:0] m_ext;
    logic signed [LO_BITS:0] h_ext;
    logic signed [LO_BITS:0] b_ext;
    ctl_t                    ctl;

    always_comb
    begin
        half  = {1'b0, cfg.max_torque[MAG_BITS-1:1]};
        n_ext = $signed({3'b000, cfg.min_torque});
        m_ext = $signed({3'b000, cfg.max_torque});
        h_ext = $signed({3'b000, half});
        b_ext = $signed({3'b000, s3_hi_reg});
        lo    = '0;
        hi    = '0;
        ctl   = '{sel_b: 1'b0, kill: 1'b1, dir_en: 1'b0};
        case (cfg.mode)
            MODE_PM:
            begin
                if (s3_pos_reg)
                begin
                    lo  = n_ext;
                    hi  = (cfg.balance < BAL_NEUTRAL) ? b_ext : m_ext;
                    ctl = '{sel_b: 1'b0, kill: 1'b0, dir_en: 1'b1};
                end
                else if (s3_neg_reg)
                begin
                    lo  = n_ext;
                    hi  = (cfg.balance >= BAL_NEUTRAL) ? b_ext : m_ext;
                    ctl = '{sel_b: 1'b1, kill: 1'b0, dir_en: 1'b1};
                end
            end
            MODE_ZFH:
            begin
                ctl = '{sel_b: 1'b0, kill: 1'b0, dir_en: 1'b1};
                if (s3_pos_reg)
                begin
                    lo = h_ext + n_ext;
                    hi = m_ext;
                end
                else if (s3_neg_reg)
                begin
                    lo = h_ext - n_ext;
                    hi = '0;
                end
                else
                begin
                    lo = h_ext;
                    hi = h_ext;
                end
            end
            MODE_PWM_DIR:
            begin
                lo  = n_ext;
                hi  = m_ext;
                ctl = '{sel_b: 1'b0, kill: 1'b0, dir_en: !s3_neg_reg};
            end
            default:
            begin
                lo  = '0;
                hi  = '0;
            end
        endcase
        span     = hi - lo;
        span_abs = span[LO_BITS] ? -span : span;
    end

    logic [MAG_BITS-1:0]  s4_mag_reg;
    logic [SPAN_BITS-1:0] s4_span_reg;
    side_t                s4_side_reg;

    // ---------------- stage 5: magnitude times span
    logic [PROD_BITS-1:0] prod;

    assign prod = {{SPAN_BITS{1'b0}}, s4_mag_reg} * {{MAG_BITS{1'b0}}, s4_span_reg};

    div_t s5_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_mag_reg <= mag_sat;
            s1_neg_reg <= in_neg;
            s1_pos_reg <= in_pos;
            s1_bal_reg <= bal_prod;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_mag_reg <= s1_mag_reg;
            s2_neg_reg <= s1_neg_reg;
            s2_pos_reg <= s1_pos_reg;
            s2_bal_reg <= s1_bal_reg;
            s2_q0_reg  <= bal_q0;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_mag_reg <= s2_mag_reg;
            s3_neg_reg <= s2_neg_reg;
            s3_pos_reg <= s2_pos_reg;
            s3_hi_reg  <= bal_hi;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_mag_reg           <= s3_mag_reg;
            s4_span_reg          <= span_abs[SPAN_BITS-1:0];
            s4_side_reg.lo       <= lo[LO_BITS-1:0];
            s4_side_reg.span_neg <= span[LO_BITS];
            s4_side_reg.ctl      <= ctl;
        end
        if (s5_ready && s4_valid_reg)
        begin
            s5_data_reg.rem  <= prod[PROD_BITS-1:SPAN_BITS];
            s5_data_reg.pq   <= prod[SPAN_BITS-1:0];
            s5_data_reg.side <= s4_side_reg;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_data  = s5_data_reg;

endmodule

/* hdl/ttpdm_div_stage.sv */
// ============================================================================
// Torque to PWM duty mapper - division stage
// One restoring step of the unsigned division by max_torque, registered.
// ============================================================================
`include "torque_to_pwm_duty_mapper_top_macros.svh"

module ttpdm_div_stage (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ttpdm_pkg::MAG_BITS-1:0]   divisor,
    input  logic                             in_valid,
    input  ttpdm_pkg::div_t                  in_data,
    output logic                             in_ready,
    output logic                             out_valid,
    output ttpdm_pkg::div_t                  out_data,
    input  logic                             out_ready
);
    import ttpdm_pkg::*;

    logic                valid_reg;
    div_t                data_reg;
    div_t                data_next;
    logic [MAG_BITS+1:0] trial;
    logic                ge;

    assign in_ready = !valid_reg || out_ready;

    // Shift the next dividend bit into the remainder and subtract if it fits.
    always_comb
    begin
        trial          = {1'b0, in_data.rem, in_data.pq[SPAN_BITS-1]} - {2'b00, divisor};
        ge             = !trial[MAG_BITS+1];
        data_next.rem  = ge ? trial[MAG_BITS-1:0]
                            : {in_data.rem[MAG_BITS-2:0], in_data.pq[SPAN_BITS-1]};
        data_next.pq   = {in_data.pq[SPAN_BITS-2:0], ge};
        data_next.side = in_data.side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `TTPDM_ASSERT_IMP(a_rem_below_divisor, valid_reg && (divisor != '0), data_reg.rem < divisor, "division remainder not below divisor")

endmodule

/* hdl/ttpdm_back.sv */
// ============================================================================
// Torque to PWM duty mapper - back end
// Applies the quotient sign, adds the low end, clamps and routes the result.
// ============================================================================
module ttpdm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ttpdm_pkg::cfg_t                   cfg,
    input  logic                              in_valid,
    input  ttpdm_pkg::div_t                   in_data,
    output logic                              in_ready,
    output logic                              out_valid,
    output logic [ttpdm_pkg::DUTY_BITS-1:0]   duty_a,
    output logic [ttpdm_pkg::DUTY_BITS-1:0]   duty_b,
    output logic                              dir_enable,
    input  logic                              out_stall
);
    import ttpdm_pkg::*;

    logic                    valid_reg;
    logic [DUTY_BITS-1:0]    duty_a_reg, duty_a_next;
    logic [DUTY_BITS-1:0]    duty_b_reg, duty_b_next;
    logic                    dir_reg;
    logic [SPAN_BITS-1:0]    quo;
    logic signed [LO_BITS:0] lo_ext;
    logic signed [LO_BITS:0] quo_ext;
    logic signed [LO_BITS:0] val;
    logic [DUTY_BITS-1:0]    duty;

    assign in_ready = !valid_reg || !out_stall;

    always_comb
    begin
        // A zero divisor only ever sees a zero dividend; the low end stands alone.
        quo     = (cfg.max_torque == '0) ? '0 : in_data.pq;
        lo_ext  = {in_data.side.lo[LO_BITS-1], in_data.side.lo};
        quo_ext = $signed({2'b00, quo});
        val     = in_data.side.span_neg ? (lo_ext - quo_ext) : (lo_ext + quo_ext);
        if (val[LO_BITS])
        begin
            duty = '0;
        end
        else if (val[LO_BITS-1:0] > {2'b00, cfg.pwm_top})
        begin
            duty = cfg.pwm_top;
        end
        else
        begin
            duty = val[DUTY_BITS-1:0];
        end
        duty_a_next = '0;
        duty_b_next = '0;
        if (!in_data.side.ctl.kill)
        begin
            if (in_data.side.ctl.sel_b)
            begin
                duty_b_next = duty;
            end
            else
            begin
                duty_a_next = duty;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            duty_a_reg <= duty_a_next;
            duty_b_reg <= duty_b_next;
            dir_reg    <= in_data.side.ctl.dir_en;
        end
    end

    assign out_valid  = valid_reg;
    assign duty_a     = duty_a_reg;
    assign duty_b     = duty_b_reg;
    assign dir_enable = dir_reg;

endmodule

/* tb/torque_to_pwm_duty_mapper_top_tb.sv */
// ============================================================================
// Torque to PWM duty mapper - testbench
// Drives torque commands through the mapper under each drive mode and a range
// of register settings, predicts every compare value and enable bit in the
// testbench, and checks each result transfer in order as it leaves the block.
// ============================================================================
module torque_to_pwm_duty_mapper_top_tb;

    import ttpdm_pkg::*;

    // Indexes five to seven of the configuration channel are not decoded by
    // the block and must leave every setting alone.
    localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REG_UNUSED_LAST  = 3'd7;

    // The fourth mode code has no enum member; the block drives all zeros.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int PIPE_LATENCY = 23;
    localparam int HOLD_CYCLES  = 200;
    localparam int ITEMS_PER_SETTING = 60;
    localparam int SETTINGS_PER_MIX  = 6;

    // Generous ceiling on the whole run, in time units.
    localparam int RUN_LIMIT = 4000000;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty_a;
        logic [DUTY_BITS-1:0] duty_b;
        logic                 dir_enable;
    } duty_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals of the block. Every input starts at a
    // known value; reset is held low only at the start of the run.
    // ------------------------------------------------------------------------
    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic [2:0]                    cfg_index    = '0;
    logic [MAG_BITS-1:0]           cfg_data     = '0;
    logic                          torque_valid = 1'b0;
    logic                          torque_stall;
    logic signed [TORQUE_BITS-1:0] torque       = '0;
    logic                          duty_valid;
    logic                          duty_stall   = 1'b0;
    logic [DUTY_BITS-1:0]          duty_a;
    logic [DUTY_BITS-1:0]          duty_b;
    logic                          dir_enable;

    always #10 clk = ~clk;

    torque_to_pwm_duty_mapper_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .torque_valid (torque_valid),
        .torque_stall (torque_stall),
        .torque       (torque),
        .duty_valid   (duty_valid),
        .duty_stall   (duty_stall),
        .duty_a       (duty_a),
        .duty_b       (duty_b),
        .dir_enable   (dir_enable)
    );

    // ------------------------------------------------------------------------
    // The testbench's own copy of the register file, kept at the widths of
    // the block. It is updated on each register transfer, and since the
    // registers only change while nothing is in flight, predicting at the
    // moment a torque transfer is accepted is always against the right
    // settings.
    // ------------------------------------------------------------------------
    logic [1:0]           cur_mode = MODE_PM;
    logic [MAG_BITS-1:0]  cur_max  = 16'd16383;
    logic [MAG_BITS-1:0]  cur_min  = 16'd0;
    logic [BAL_BITS-1:0]  cur_bal  = 8'd128;
    logic [DUTY_BITS-1:0] cur_top  = 16'd16383;

    duty_result_t expected_duties[$];
    duty_result_t want_duty;

    int send_idle_pct   = 20;
    int recv_stall_pct  = 20;
    int mismatch_count  = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int cfg_writes      = 0;

    // Long output hold-off: a toggle of hold_req asks the receiver for one.
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    // Linear map of the saturated magnitude from lo to hi, dividing by
    // max_torque with truncation towards zero. A zero divisor yields lo.
    function automatic longint map_span(input longint mag, input longint lo,
                                        input longint hi);
        if (cur_max == '0)
            return lo;
        return lo + (mag * (hi - lo)) / longint'(cur_max);
    endfunction

    // Compare values never go below zero or above the timer top.
    function automatic logic [DUTY_BITS-1:0] clamp_duty(input longint v);
        if (v < 0)
            return '0;
        if (v > longint'(cur_top))
            return cur_top;
        return v[DUTY_BITS-1:0];
    endfunction

    function automatic duty_result_t predict_duty(input logic signed [TORQUE_BITS-1:0] cmd);
        longint       mag;
        longint       top_m;
        longint       floor_n;
        longint       bal;
        longint       hi;
        logic         neg;
        logic         pos;
        duty_result_t r;
        neg     = cmd[TORQUE_BITS-1];
        mag     = neg ? -longint'(cmd) : longint'(cmd);
        pos     = !neg && (mag != 0);
        top_m   = longint'(cur_max);
        floor_n = longint'(cur_min);
        bal     = longint'(cur_bal);
        r       = '0;
        // Saturate the magnitude before any mapping.
        if (mag > top_m)
            mag = top_m;
        case (cur_mode)
            MODE_PM:
            begin
                // The balance trims the upper bound of one side only.
                if (pos)
                begin
                    hi = (bal < 128) ? (top_m * (bal + 127)) / 255 : top_m;
                    r.duty_a     = clamp_duty(map_span(mag, floor_n, hi));
                    r.dir_enable = 1'b1;
                end
                else if (neg)
                begin
                    hi = (bal >= 128) ? (top_m * (383 - bal)) / 255 : top_m;
                    r.duty_b     = clamp_duty(map_span(mag, floor_n, hi));
                    r.dir_enable = 1'b1;
                end
            end
            MODE_ZFH:
            begin
                if (pos)
                    r.duty_a = clamp_duty(map_span(mag, top_m / 2 + floor_n, top_m));
                else if (neg)
                    r.duty_a = clamp_duty(map_span(mag, top_m / 2 - floor_n, 0));
                else
                    r.duty_a = clamp_duty(top_m / 2);
                r.dir_enable = 1'b1;
            end
            MODE_PWM_DIR:
            begin
                r.duty_a     = clamp_duty(map_span(mag, floor_n, top_m));
                r.dir_enable = !neg;
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random values for registers and commands. Register levels lean towards
    // the extremes; commands mix zero, the widest values, values straddling
    // the saturation point, values inside the mapped range and plain noise
    // over all seventeen bits.
    // ------------------------------------------------------------------------
    function automatic logic [MAG_BITS-1:0] pick_level();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'd1;
            3, 4:    return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [MAG_BITS-1:0] pick_balance();
        logic [MAG_BITS-1:0] v;
        v = 16'($urandom);
        case ($urandom_range(5))
            0:       v[7:0] = 8'd0;
            1:       v[7:0] = 8'd127;
            2:       v[7:0] = 8'd128;
            3:       v[7:0] = 8'd255;
            default: v[7:0] = 8'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic signed [TORQUE_BITS-1:0] pick_torque();
        logic signed [TORQUE_BITS-1:0] v;
        int                            mag;
        case ($urandom_range(9))
            0:
            begin
                v = '0;
            end
            1:
            begin
                v = $urandom_range(1) ? 17'sh0FFFF : 17'sh10000;
            end
            2, 3:
            begin
                mag = int'(cur_max) + int'($urandom_range(2)) - 1;
                if (mag < 0)
                    mag = 0;
                v = 17'(mag);
                if ($urandom_range(1))
                    v = -v;
            end
            4, 5:
            begin
                v = 17'($urandom_range(cur_max));
                if ($urandom_range(1))
                    v = -v;
            end
            default:
            begin
                v = 17'($urandom);
            end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", results_checked, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Sender. One torque transfer per call; the sender idles at random before
    // offering it, puts noise on the bus while idle, and holds the payload
    // steady while the block stalls. The expectation is queued at the edge
    // where the transfer happens. The valid is left high on return so that
    // back-to-back transfers need only one assignment per edge; it is lowered
    // by wait_drained.
    // ------------------------------------------------------------------------
    task automatic send_torque(input logic signed [TORQUE_BITS-1:0] cmd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            torque_valid <= 1'b0;
            torque       <= 17'($urandom);
            @(posedge clk);
        end
        torque_valid <= 1'b1;
        torque       <= cmd;
        do
            @(posedge clk);
        while (torque_stall);
        expected_duties.push_back(predict_duty(cmd));
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result to arrive. The task
    // always passes a clock edge before it returns, so calls in a row lower the
    // valid at separate edges.
    task automatic wait_drained();
        torque_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_duties.size() != 0);
    endtask

    // One register transfer. The predictor's copy keeps only the bits that
    // the register holds; unused indexes change nothing. The final wait for a
    // clock edge keeps each edge to a single assignment of cfg_valid.
    task automatic write_reg(input logic [2:0] idx, input logic [MAG_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DRIVE_MODE: cur_mode = data[1:0];
            REG_MAX_TORQUE: cur_max  = data;
            REG_MIN_TORQUE: cur_min  = data;
            REG_BALANCE:    cur_bal  = data[BAL_BITS-1:0];
            REG_PWM_TOP:    cur_top  = data;
            default:        ;
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [1:0] mode, input logic [15:0] max_t,
                                 input logic [15:0] min_t, input logic [7:0] bal,
                                 input logic [15:0] top);
        wait_drained();
        write_reg(REG_DRIVE_MODE, 16'(mode));
        write_reg(REG_MAX_TORQUE, max_t);
        write_reg(REG_MIN_TORQUE, min_t);
        write_reg(REG_BALANCE, 16'(bal));
        write_reg(REG_PWM_TOP, top);
    endtask

    // ------------------------------------------------------------------------
    // Receiver. It stalls at random at the rate of the current mix, except
    // during a requested hold-off, when it stalls throughout its length so that
    // the pipeline fills and the block stalls its input in turn.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            duty_stall <= 1'b1;
            hold_left  <= hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen  <= hold_req;
            hold_left  <= HOLD_CYCLES - 1;
            duty_stall <= 1'b1;
        end
        else
        begin
            duty_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Checker: every result transfer is matched against the oldest
    // expectation, field by field. Values are those present at the edge.
    always @(posedge clk)
    begin
        if (rst_n && duty_valid && !duty_stall)
        begin
            if (expected_duties.size() == 0)
            begin
                report_mismatch($sformatf("result with none expected: a=%0d b=%0d en=%0b",
                                          duty_a, duty_b, dir_enable));
            end
            else
            begin
                want_duty = expected_duties.pop_front();
                if (duty_a !== want_duty.duty_a)
                    report_mismatch($sformatf("duty_a got %0d, expected %0d",
                                              duty_a, want_duty.duty_a));
                if (duty_b !== want_duty.duty_b)
                    report_mismatch($sformatf("duty_b got %0d, expected %0d",
                                              duty_b, want_duty.duty_b));
                if (dir_enable !== want_duty.dir_enable)
                    report_mismatch($sformatf("dir_enable got %0b, expected %0b",
                                              dir_enable, want_duty.dir_enable));
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Settings straight out of reset: plus/minus drive, neutral balance.
    // Covers zero, the smallest magnitudes, full scale and saturation from
    // both ends of the input range.
    task automatic test_reset_state();
        send_torque(17'sd0);
        send_torque(17'sd1);
        send_torque(-17'sd1);
        send_torque(17'sd16383);
        send_torque(-17'sd16383);
        send_torque(17'sh0FFFF);
        send_torque(17'sh10000);
    endtask

    // Each of the other modes, the unused mode code included, with a
    // dead-band floor so that the offset shows in the mapped values.
    task automatic test_mode_spans();
        load_settings(MODE_ZFH, 16'd16383, 16'd100, 8'd128, 16'd16383);
        send_torque(17'sd0);
        send_torque(17'sd16383);
        send_torque(-17'sd16383);
        load_settings(MODE_PWM_DIR, 16'd16383, 16'd100, 8'd128, 16'd16383);
        send_torque(17'sd0);
        send_torque(17'sd5000);
        send_torque(-17'sd5000);
        load_settings(MODE_UNUSED, 16'd16383, 16'd100, 8'd128, 16'd16383);
        send_torque(17'sd1234);
        send_torque(-17'sd1234);
    endtask

    // Balance at both ends trims the positive side and then the negative one.
    task automatic test_balance_extremes();
        load_settings(MODE_PM, 16'd16383, 16'd0, 8'd0, 16'd65535);
        send_torque(17'sd16383);
        send_torque(-17'sd16383);
        load_settings(MODE_PM, 16'd16383, 16'd0, 8'd255, 16'd65535);
        send_torque(17'sd16383);
        send_torque(-17'sd16383);
    endtask

    // Zero max_torque collapses every magnitude to the floor, a low timer top
    // clamps the floor from above, and a floor larger than half scale drives
    // the negative side of zero-fifty-hundred drive below zero.
    task automatic test_clamp_limits();
        load_settings(MODE_PWM_DIR, 16'd0, 16'd300, 8'd128, 16'd200);
        send_torque(17'sd500);
        send_torque(-17'sd500);
        load_settings(MODE_ZFH, 16'd1000, 16'd800, 8'd128, 16'd16383);
        send_torque(-17'sd1000);
        send_torque(-17'sd200);
    endtask

    // ------------------------------------------------------------------------
    // Random tests.
    // ------------------------------------------------------------------------

    // One idle mix: several register settings, each followed by a burst of
    // random commands. The upper bits of the narrow registers carry noise,
    // and now and then an undecoded index is written as well.
    task automatic test_random_mix(input int send_pct, input int recv_pct);
        logic [15:0] mode_word;
        wait_drained();
        send_idle_pct   = send_pct;
        recv_stall_pct <= recv_pct;
        repeat (SETTINGS_PER_MIX)
        begin
            wait_drained();
            mode_word      = 16'($urandom);
            mode_word[1:0] = ($urandom_range(7) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
            write_reg(REG_DRIVE_MODE, mode_word);
            write_reg(REG_MAX_TORQUE, ($urandom_range(9) == 0) ? 16'd0 : pick_level());
            write_reg(REG_MIN_TORQUE, pick_level());
            write_reg(REG_BALANCE, pick_balance());
            write_reg(REG_PWM_TOP, pick_level());
            if ($urandom_range(2) == 0)
                write_reg(3'($urandom_range(REG_UNUSED_LAST, REG_UNUSED_FIRST)),
                          16'($urandom));
            repeat (ITEMS_PER_SETTING)
                send_torque(pick_torque());
        end
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering commands without a gap, so the pipeline fills completely and
    // the block must stall its input until the hold-off ends.
    task automatic test_output_backpressure();
        wait_drained();
        load_settings(MODE_PM, 16'd40000, 16'd50, 8'd200, 16'd60000);
        send_idle_pct   = 0;
        recv_stall_pct <= 0;
        hold_req       <= ~hold_req;
        repeat (80)
            send_torque(pick_torque());
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_mode_spans();
        test_balance_extremes();
        test_clamp_limits();
        test_random_mix(38, 82);
        test_random_mix(82, 38);
        test_output_backpressure();
        test_random_mix(0, 0);

        // Let any stray result surface before the verdict.
        wait_drained();
        repeat (2 * PIPE_LATENCY) @(posedge clk);

        $display("Run covered %0d torque transfers and %0d register writes: all modes,",
                 items_sent, cfg_writes);
        $display("three idle mixes and a long output hold-off; %0d results checked, %0d bad.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && expected_duties.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial
    begin
        #(RUN_LIMIT);
        $display("Run stopped by the watchdog with %0d results outstanding.",
                 expected_duties.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* torque_to_pwm_duty_mapper_top.f */
+incdir+hdl
hdl/ttpdm_pkg.sv
hdl/ttpdm_front.sv
hdl/ttpdm_div_stage.sv
hdl/ttpdm_back.sv
hdl/torque_to_pwm_duty_mapper_top.sv
tb/torque_to_pwm_duty_mapper_top_tb.sv
